@@ hdl/adc_pkg.sv @@
// shared types and constants of the angle delta batch compressor
package adc_pkg;

  // frame layout and field widths
  localparam int FrameW      = 64;
  localparam int FrameInputs = 4;
  localparam int AngleW      = 14;
  localparam int AngleLsb    = 50;
  localparam int TsW         = 32;
  localparam int TsLsb       = 18;
  localparam int SocW        = 8;
  localparam int SocLsb      = 10;
  localparam int FlagsW      = 10;
  localparam int CountW      = 10;

  // record sizing, taken for the largest sensor count
  localparam int MaxSensors  = 8;
  localparam int MaxRecBytes = 10 + 2 * MaxSensors;
  localparam int IdxW        = $clog2(MaxRecBytes);

  // queue between front and back
  localparam int QDepth      = 2;
  localparam int QPtrW       = $clog2(QDepth);

  // header version byte
  localparam logic [7:0] HdrVersion = 8'd2;

  // one queued record: its bytes in wire order and the index of its last byte
  typedef struct packed {
    logic [MaxRecBytes-1:0][7:0] data;
    logic [IdxW-1:0]             last_idx;
  } rec_t;

  // queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

@@ hdl/adc_front.sv @@
// front part: accepts items, classifies them and builds header or delta records
module adc_front #(
  parameter int SENSORS   = 4,
  parameter int MAX_BATCH = 512
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic [adc_pkg::FrameInputs-1:0][adc_pkg::FrameW-1:0] frames_i,
  input  logic                                       batch_start_i,
  input  logic [adc_pkg::CountW-1:0]                 batch_count_i,
  input  adc_pkg::q_stat_t                           q_stat_i,
  output logic                                       push_o,
  output adc_pkg::rec_t                              rec_o
);

  localparam logic [adc_pkg::IdxW-1:0] HdrLast = adc_pkg::IdxW'(9 + 2 * SENSORS);
  localparam logic [adc_pkg::IdxW-1:0] DltLast = adc_pkg::IdxW'(SENSORS + 1);
  localparam logic [16:0]              MaxCnt  = 17'(MAX_BATCH);

  // wrapped and saturated angle delta as a signed byte
  function automatic logic [7:0] delta_byte(input logic [adc_pkg::AngleW-1:0] cur,
                                            input logic [adc_pkg::AngleW-1:0] prev);
    logic signed [15:0] d;
    d = $signed({2'b00, cur}) - $signed({2'b00, prev});
    if (d > 16'sd8192) begin
      d = d - 16'sd16384;
    end else if (d < -16'sd8192) begin
      d = d + 16'sd16384;
    end
    if (d > 16'sd127) begin
      d = 16'sd127;
    end else if (d < -16'sd128) begin
      d = -16'sd128;
    end
    return d[7:0];
  endfunction

  logic [adc_pkg::AngleW-1:0] prev_ang_q [SENSORS];
  logic [adc_pkg::AngleW-1:0] prev_ang_d [SENSORS];
  logic [adc_pkg::AngleW-1:0] ang        [SENSORS];
  logic [adc_pkg::TsW-1:0]    prev_ts_q, prev_ts_d;
  logic [adc_pkg::TsW-1:0]    ts;
  logic [15:0]                dts;
  logic [15:0]                cnt_sat;
  logic [adc_pkg::SocW-1:0]   soc;
  logic [adc_pkg::FlagsW-1:0] flags;
  logic                       accept;
  logic                       drop;

  // field extraction, sensors past the frame inputs read as zero
  always_comb begin
    for (int s = 0; s < SENSORS; s++) begin
      if (s < adc_pkg::FrameInputs) begin
        ang[s] = frames_i[s][adc_pkg::AngleLsb +: adc_pkg::AngleW];
      end else begin
        ang[s] = '0;
      end
    end
  end

  assign ts    = frames_i[0][adc_pkg::TsLsb +: adc_pkg::TsW];
  assign soc   = frames_i[0][adc_pkg::SocLsb +: adc_pkg::SocW];
  assign flags = frames_i[0][adc_pkg::FlagsW-1:0];
  assign dts   = 16'(ts - prev_ts_q);

  // count saturation for the header
  assign cnt_sat = (17'(batch_count_i) > MaxCnt) ? MaxCnt[15:0] : 16'(batch_count_i);

  // classification: an empty batch start makes no record and keeps the state
  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign drop       = batch_start_i && (batch_count_i == '0);
  assign push_o     = accept && !drop;

  // record build
  always_comb begin
    rec_o = '0;
    if (batch_start_i) begin
      rec_o.data[0] = adc_pkg::HdrVersion;
      rec_o.data[1] = cnt_sat[7:0];
      rec_o.data[2] = cnt_sat[15:8];
      rec_o.data[3] = ts[7:0];
      rec_o.data[4] = ts[15:8];
      rec_o.data[5] = ts[23:16];
      rec_o.data[6] = ts[31:24];
      for (int s = 0; s < SENSORS; s++) begin
        rec_o.data[7 + 2 * s] = ang[s][7:0];
        rec_o.data[8 + 2 * s] = {2'b00, ang[s][adc_pkg::AngleW-1:8]};
      end
      rec_o.data[7 + 2 * SENSORS] = soc;
      rec_o.data[8 + 2 * SENSORS] = flags[7:0];
      rec_o.data[9 + 2 * SENSORS] = {6'b000000, flags[adc_pkg::FlagsW-1:8]};
      rec_o.last_idx = HdrLast;
    end else begin
      for (int s = 0; s < SENSORS; s++) begin
        rec_o.data[s] = delta_byte(ang[s], prev_ang_q[s]);
      end
      rec_o.data[SENSORS]     = dts[7:0];
      rec_o.data[SENSORS + 1] = dts[15:8];
      rec_o.last_idx = DltLast;
    end
  end

  // reference state update
  always_comb begin
    prev_ts_d = prev_ts_q;
    for (int s = 0; s < SENSORS; s++) begin
      prev_ang_d[s] = prev_ang_q[s];
    end
    if (push_o) begin
      prev_ts_d = ts;
      for (int s = 0; s < SENSORS; s++) begin
        prev_ang_d[s] = ang[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ts_q <= '0;
      for (int s = 0; s < SENSORS; s++) begin
        prev_ang_q[s] <= '0;
      end
    end else begin
      prev_ts_q <= prev_ts_d;
      for (int s = 0; s < SENSORS; s++) begin
        prev_ang_q[s] <= prev_ang_d[s];
      end
    end
  end

endmodule

@@ hdl/adc_queue.sv @@
// short record queue between the front and the back
module adc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  adc_pkg::rec_t    wdata_i,
  input  logic             pop_i,
  output adc_pkg::rec_t    rdata_o,
  output adc_pkg::q_stat_t stat_o
);

  localparam logic [adc_pkg::QPtrW:0] Depth = (adc_pkg::QPtrW + 1)'(adc_pkg::QDepth);

  adc_pkg::rec_t            mem [adc_pkg::QDepth];
  logic [adc_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [adc_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [adc_pkg::QPtrW:0]   cnt_q, cnt_d;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == Depth);
  assign rdata_o      = mem[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == adc_pkg::QPtrW'(adc_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == adc_pkg::QPtrW'(adc_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // record storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ hdl/adc_back.sv @@
// back part: serializes the head record into bytes through an output register
module adc_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  adc_pkg::rec_t            rec_i,
  input  adc_pkg::q_stat_t         q_stat_i,
  output logic                     pop_o,
  output logic [adc_pkg::IdxW-1:0] idx_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               out_byte_o,
  output logic                     out_last_o
);

  logic [adc_pkg::IdxW-1:0] idx_q, idx_d;
  logic                     valid_q, valid_d;
  logic [7:0]               byte_q, byte_d;
  logic                     last_q, last_d;
  logic                     load;
  logic                     at_last;

  assign load    = !valid_q || out_ready_i;
  assign at_last = (idx_q == rec_i.last_idx);
  assign pop_o   = load && !q_stat_i.empty && at_last;

  // byte select and index step
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (load) begin
      valid_d = !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        byte_d = rec_i.data[idx_q];
        last_d = at_last;
        idx_d  = at_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign idx_o       = idx_q;

endmodule

@@ hdl/angle_delta_batch_compressor.sv @@
// top level of the angle delta batch compressor
//
//  port group   dir  payload
//  s_axis       in   tdata: frame_sensor0..3, batch_count; tuser: batch_start
//  m_axis       out  tdata: out_byte; tlast: run_last
//
// an item is taken and turned into a whole record at once
// the back sends one byte a cycle while m_axis is ready: SENSORS + 2 bytes for a delta item,
// 10 + 2 * SENSORS bytes for a header item; the byte serializer sets the rate
// a two-entry record queue lets the input take items while bytes still drain
// reset clears the angle and timestamp references, the queue and the output stage
// a stall on m_axis holds the output byte; s_axis stalls only when the queue is full
module angle_delta_batch_compressor #(
  parameter int SENSORS   = 4,
  parameter int MAX_BATCH = 512
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // frame_sensor0 [63:0], frame_sensor1 [127:64], frame_sensor2 [191:128],
  // frame_sensor3 [255:192], batch_count [265:256], zero fill [271:266]
  input  logic [271:0] s_axis_tdata_i,
  // batch_start [0]
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_byte [7:0]
  output logic [7:0]   m_axis_tdata_o,
  output logic         m_axis_tlast_o
);

  logic [adc_pkg::FrameInputs-1:0][adc_pkg::FrameW-1:0] frames;
  adc_pkg::rec_t            rec_in;
  adc_pkg::rec_t            rec_head;
  adc_pkg::q_stat_t         q_stat;
  logic                     push;
  logic                     pop;
  logic [adc_pkg::IdxW-1:0] back_idx;
  logic                     in_acc;
  logic                     out_acc;
  logic                     empty_start;

  assign frames = s_axis_tdata_i[adc_pkg::FrameInputs*adc_pkg::FrameW-1:0];

  adc_front #(
    .SENSORS  (SENSORS),
    .MAX_BATCH(MAX_BATCH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .frames_i     (frames),
    .batch_start_i(s_axis_tuser_i[0]),
    .batch_count_i(s_axis_tdata_i[265:256]),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .rec_o        (rec_in)
  );

  adc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(rec_in),
    .pop_i  (pop),
    .rdata_o(rec_head),
    .stat_o (q_stat)
  );

  adc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_i      (rec_head),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .idx_o      (back_idx),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_byte_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o)
  );

  assign in_acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc     = m_axis_tvalid_o && m_axis_tready_i;
  assign empty_start = s_axis_tuser_i[0] && (s_axis_tdata_i[265:256] == '0);

  // a producing item always lands in the queue
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !empty_start |=> !q_stat.empty)
    else $error("accepted item left no record in the queue");

  // an empty batch start never creates a record
  a_empty_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && empty_start && q_stat.empty |=> q_stat.empty)
    else $error("empty batch start produced a record");

  // the serializer index returns to zero whenever a record is finished
  a_idx_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> back_idx == '0)
    else $error("byte index not cleared after record end");

  // a popped record always ends with a last byte on the output
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> m_axis_tvalid_o && m_axis_tlast_o)
    else $error("record popped without a last byte");

  // no last byte is sent unless the queue had been drained of that record
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && m_axis_tlast_o |-> back_idx == '0)
    else $error("last byte sent while a record is half done");

endmodule

@@ tb/angle_delta_batch_compressor_test.sv @@
// self-checking testbench of the angle delta batch compressor
`timescale 1ns / 1ps

module angle_delta_batch_compressor_test;

  localparam int Sensors     = 4;
  localparam int MaxBatch    = 512;
  localparam int RandomItems = 80;
  localparam int DrainCycles = 64;
  localparam int CycleLimit  = 600000;

  typedef logic [adc_pkg::FrameInputs-1:0][adc_pkg::FrameW-1:0] frames_t;

  // one input item; lit_len < 0 means the predictor supplies the bytes
  typedef struct {
    frames_t                    frames;
    logic                       start;
    logic [adc_pkg::CountW-1:0] count;
    int                         lit_len;
    logic [143:0]               lit;
  } sample_t;

  // one byte of the wire stream
  typedef struct {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  logic         clk;
  logic         rst_n   = 1'b0;
  logic         s_valid = 1'b0;
  logic [271:0] s_data  = '0;
  logic [0:0]   s_user  = 1'b0;
  logic         m_ready = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [7:0]   m_axis_tdata_o;
  logic         m_axis_tlast_o;

  // compressor state as the predictor sees it
  logic [adc_pkg::AngleW-1:0] ref_angle [Sensors];
  logic [adc_pkg::TsW-1:0]    ref_ts;
  logic [7:0]                 rec_bytes [18];
  int                         rec_len;

  wire_byte_t bytes_due [$];
  sample_t    directed_rows [$];
  int         err_count    = 0;
  int         cycle_count  = 0;
  int         rx_count     = 0;
  int         samples_sent = 0;
  int         stall_left   = 0;
  bit         calm         = 1'b0;

  angle_delta_batch_compressor #(
    .SENSORS  (Sensors),
    .MAX_BATCH(MaxBatch)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  // idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    rec_bytes[rec_len] = b;
    rec_len++;
  endfunction

  // angle difference wrapped into half a turn, then clamped to a signed byte
  function automatic logic [7:0] angle_step(input logic [adc_pkg::AngleW-1:0] cur,
                                            input logic [adc_pkg::AngleW-1:0] prev);
    int d;
    d = cur;
    d = d - prev;
    if (d > 8192) d -= 16384;
    if (d < -8192) d += 16384;
    if (d > 127) d = 127;
    if (d < -128) d = -128;
    return d[7:0];
  endfunction

  // build the record of one sample and advance the reference state
  function automatic void encode_sample(input sample_t smp);
    logic [adc_pkg::TsW-1:0]    ts;
    logic [15:0]                cnt;
    logic [15:0]                dts;
    logic [adc_pkg::AngleW-1:0] ang;
    ts = smp.frames[0][adc_pkg::TsLsb +: adc_pkg::TsW];
    rec_len = 0;
    if (smp.start) begin
      // a zero count header is dropped without touching the state
      if (smp.count == 0) return;
      cnt = (smp.count > MaxBatch) ? 16'(MaxBatch) : 16'(smp.count);
      put_byte(adc_pkg::HdrVersion);
      put_byte(cnt[7:0]);
      put_byte(cnt[15:8]);
      for (int k = 0; k < 4; k++) put_byte(ts[8*k +: 8]);
      for (int s = 0; s < Sensors; s++) begin
        ang = smp.frames[s][adc_pkg::AngleLsb +: adc_pkg::AngleW];
        put_byte(ang[7:0]);
        put_byte({2'b00, ang[13:8]});
        ref_angle[s] = ang;
      end
      put_byte(smp.frames[0][adc_pkg::SocLsb +: adc_pkg::SocW]);
      put_byte(smp.frames[0][7:0]);
      put_byte({6'b0, smp.frames[0][adc_pkg::FlagsW-1:8]});
    end else begin
      dts = ts[15:0] - ref_ts[15:0];
      for (int s = 0; s < Sensors; s++) begin
        ang = smp.frames[s][adc_pkg::AngleLsb +: adc_pkg::AngleW];
        put_byte(angle_step(ang, ref_angle[s]));
        ref_angle[s] = ang;
      end
      put_byte(dts[7:0]);
      put_byte(dts[15:8]);
    end
    ref_ts = ts;
  endfunction

  // queue the bytes due for an accepted item, typed-in ones where given
  function automatic void note_accepted(input sample_t smp);
    wire_byte_t b;
    int         n;
    encode_sample(smp);
    n = (smp.lit_len < 0) ? rec_len : smp.lit_len;
    for (int i = 0; i < n; i++) begin
      b.data = (smp.lit_len < 0) ? rec_bytes[i] : smp.lit[8*i +: 8];
      b.last = (i == n - 1);
      bytes_due.push_back(b);
    end
  endfunction

  function automatic logic [adc_pkg::FrameW-1:0] mk_frame(
      input logic [adc_pkg::AngleW-1:0] angle,
      input logic [adc_pkg::TsW-1:0]    ts,
      input logic [adc_pkg::SocW-1:0]   soc,
      input logic [adc_pkg::FlagsW-1:0] flags);
    return {angle, ts, soc, flags};
  endfunction

  function automatic sample_t row(input frames_t frames, input logic start,
                                  input logic [adc_pkg::CountW-1:0] count,
                                  input int lit_len, input logic [143:0] lit);
    sample_t smp;
    smp.frames  = frames;
    smp.start   = start;
    smp.count   = count;
    smp.lit_len = lit_len;
    smp.lit     = lit;
    return smp;
  endfunction

  function automatic frames_t noise_frames();
    frames_t f;
    for (int s = 0; s < adc_pkg::FrameInputs; s++) f[s] = {$urandom, $urandom};
    return f;
  endfunction

  // frames near the current reference: small steps, steps across half a turn, or noise
  function automatic frames_t fresh_frames(input int mode);
    frames_t                    f;
    logic [adc_pkg::AngleW-1:0] ang;
    f = noise_frames();
    for (int s = 0; s < Sensors; s++) begin
      ang = f[s][adc_pkg::AngleLsb +: adc_pkg::AngleW];
      if (mode == 0) ang = ref_angle[s] + 14'($urandom_range(0, 300)) - 14'd150;
      else if (mode == 1) ang = ref_angle[s] + 14'd8192 + 14'($urandom_range(0, 20)) - 14'd10;
      f[s][adc_pkg::AngleLsb +: adc_pkg::AngleW] = ang;
    end
    if ($urandom_range(0, 4) != 0)
      f[0][adc_pkg::TsLsb +: adc_pkg::TsW] = ref_ts + $urandom_range(0, 3000);
    return f;
  endfunction

  // drive one item and wait for it to be taken
  task automatic send_sample(input sample_t smp);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {6'b0, smp.count, smp.frames};
    s_user  <= smp.start;
    do @(posedge clk); while (!s_axis_tready_o);
    note_accepted(smp);
    if (!(smp.start && smp.count == 0)) samples_sent++;
  endtask

  task automatic send_random(input logic start, input logic [adc_pkg::CountW-1:0] count,
                             input int mode);
    sample_t smp;
    smp = row(fresh_frames(mode), start, count, -1, '0);
    send_sample(smp);
  endtask

  // byte sink: check each taken byte, then pick the next ready
  always @(posedge clk) begin : byte_sink
    wire_byte_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      if (bytes_due.size() == 0) begin
        report_mismatch($sformatf("byte %0d: %0h with nothing expected", rx_count,
                                  m_axis_tdata_o));
      end else begin
        want = bytes_due.pop_front();
        if (m_axis_tdata_o !== want.data)
          report_mismatch($sformatf("byte %0d out_byte: got %0h, expected %0h", rx_count,
                                    m_axis_tdata_o, want.data));
        if (m_axis_tlast_o !== want.last)
          report_mismatch($sformatf("byte %0d run_last: got %0b, expected %0b", rx_count,
                                    m_axis_tlast_o, want.last));
      end
      rx_count <= rx_count + 1;
    end
    if (stall_left > 0) begin
      m_ready    <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("TEST FAILED");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int r;
    int cnt;
    int n_delta;
    logic [adc_pkg::CountW-1:0] count;
    for (int s = 0; s < Sensors; s++) ref_angle[s] = '0;
    ref_ts = '0;

    // delta records straight after reset use zero references
    directed_rows.push_back(row('0, 1'b0, '0, 6, 144'h0));
    directed_rows.push_back(row('1, 1'b0, '0, 6, 144'hFF_FF_FF_FF_FF_FF));
    // a zero count header gives nothing
    directed_rows.push_back(row({4{mk_frame(14'h1234, 32'hDEAD_BEEF, 8'h5A, 10'h155)}},
                                1'b1, '0, 0, 144'h0));
    // all ones header, count clamped to the batch maximum
    directed_rows.push_back(row('1, 1'b1, 10'd1023, 18,
      144'h03_FF_FF_3F_FF_3F_FF_3F_FF_3F_FF_FF_FF_FF_FF_02_00_02));
    // from full scale back to zero wraps to a step of one
    directed_rows.push_back(row('0, 1'b0, 10'd1023, 6, 144'h00_01_01_01_01_01));
    directed_rows.push_back(row('0, 1'b1, 10'd1, 18, 144'h01_02));
    // steps at the half-turn and clamp edges
    directed_rows.push_back(row({mk_frame(14'd128, '0, '0, '0), mk_frame(14'd127, '0, '0, '0),
                                 mk_frame(14'd8193, '0, '0, '0),
                                 mk_frame(14'd8192, 32'd5, '0, '0)}, 1'b0, '0, -1, '0));
    directed_rows.push_back(row({mk_frame(14'd0, '1, '1, '1), mk_frame(14'd0, '0, '0, '0),
                                 mk_frame(14'd8064, '0, '0, '0),
                                 mk_frame(14'd8064, 32'd4, '0, '0)}, 1'b0, '0, -1, '0));
    // soc and flags of a delta item play no part
    directed_rows.push_back(row({mk_frame(14'h3F00, '0, '0, '0), mk_frame(14'd1, '0, '0, '0),
                                 mk_frame(14'h2000, '0, '0, '0),
                                 mk_frame(14'd100, 32'h0001_2345, 8'hA5, 10'h2AA)},
                                1'b0, 10'h155, -1, '0));
    directed_rows.push_back(row(noise_frames(), 1'b1, 10'd512, -1, '0));
    directed_rows.push_back(row(noise_frames(), 1'b1, 10'd513, -1, '0));
    directed_rows.push_back(row(noise_frames(), 1'b0, '0, -1, '0));
    directed_rows.push_back(row(noise_frames(), 1'b1, 10'h2AA, -1, '0));
    directed_rows.push_back(row(noise_frames(), 1'b1, 10'h155, -1, '0));
    // deltas past the announced count still come out
    directed_rows.push_back(row(noise_frames(), 1'b1, 10'd1, -1, '0));
    directed_rows.push_back(row(noise_frames(), 1'b0, 10'h2AA, -1, '0));
    directed_rows.push_back(row(noise_frames(), 1'b0, '0, -1, '0));
    directed_rows.push_back(row(noise_frames(), 1'b0, 10'h3FF, -1, '0));

    // reset
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (directed_rows[i]) send_sample(directed_rows[i]);

    // random batches: header then deltas, with some broken sequences
    samples_sent = 0;
    while (samples_sent < RandomItems) begin
      calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 3)) send_random(1'b0, adc_pkg::CountW'($urandom), 2);
      end
      r = $urandom_range(0, 99);
      if (r < 75) begin
        count = adc_pkg::CountW'($urandom_range(1, 10));
      end else begin
        case ($urandom_range(0, 4))
          0:       count = '0;
          1:       count = 10'd512;
          2:       count = 10'd513;
          3:       count = 10'd1023;
          default: count = adc_pkg::CountW'($urandom);
        endcase
      end
      send_random(1'b1, count, 2);
      cnt = (count > 15) ? 15 : count;
      r = $urandom_range(0, 99);
      if (r < 70) n_delta = (cnt > 0) ? cnt - 1 : 0;
      else if (r < 85) n_delta = cnt + $urandom_range(0, 3);
      else n_delta = $urandom_range(0, cnt);
      repeat (n_delta) begin
        r = $urandom_range(0, 99);
        send_random(1'b0, adc_pkg::CountW'($urandom), (r < 70) ? 0 : ((r < 85) ? 1 : 2));
      end
    end
    s_valid <= 1'b0;
    calm = 1'b0;

    // drain and let any stray byte show up
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
